// ===== hw/rtl/spi_ma_pkg.sv =====
package spi_ma_pkg;

   // request queue between front and engine
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;
   localparam int QUEUE_CNT_W = 3;

   // command codes
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_READ  = 1'b1;

   // register file: one word per 4 bytes, index taken from paddr[2]
   localparam int          CSR_ADDR_W   = 3;
   localparam logic        CSR_IDX_HALF = 1'b0;
   localparam logic [7:0]  HALF_RESET   = 8'd1;

   // one queued request, one tick of serial timing
   typedef struct packed {
      logic        start_req;
      logic        command;
      logic [14:0] address;
      logic [7:0]  write_data;
      logic        miso;
   } req_item_type;

   // queue status seen by the engine
   typedef struct packed {
      logic                   valid;
      logic [QUEUE_CNT_W-1:0] level;
   } queue_status_type;

endpackage

// ===== hw/rtl/spi_ma_req_if.sv =====
interface spi_ma_req_if;
   logic        valid;
   logic        ready;
   logic        start_req;
   logic        command;
   logic [14:0] address;
   logic [7:0]  write_data;
   logic        miso;

   modport source (output valid, start_req, command, address, write_data, miso,
                   input ready);
   modport sink (input valid, start_req, command, address, write_data, miso,
                 output ready);
endinterface

// ===== hw/rtl/spi_ma_rsp_if.sv =====
interface spi_ma_rsp_if;
   logic       valid;
   logic       ready;
   logic       chip_select_n;
   logic       serial_clock;
   logic       serial_out;
   logic       busy_res;
   logic       done_res;
   logic [7:0] read_data;

   modport source (output valid, chip_select_n, serial_clock, serial_out, busy_res,
                   done_res, read_data, input ready);
   modport sink (input valid, chip_select_n, serial_clock, serial_out, busy_res,
                 done_res, read_data, output ready);
endinterface

// ===== hw/rtl/spi_master_addr16_data8.sv =====
// SPI master (mode 0) for one register access: ADDRESS_BITS address bits, MSB
// first with the top bit set for a read, then DATA_BITS data bits.
// req_bus: one request per tick of serial timing (start_req, command, address,
// write_data, miso). A start while a frame runs is ignored.
// rsp_bus: one response per request with the pin levels after that tick
// (chip_select_n, serial_clock, serial_out), busy_res, a done_res pulse on the
// tick that ends the frame, and read_data from the last finished read.
// csr_*: APB write/read of half_period_ticks at byte address 0 (0 acts as 1);
// write it only while no frame runs and no request is in flight.
// Throughput: one request per cycle while the queue has room. An accepted
// request lands in the 4-entry request queue and is popped into the response
// register of the frame engine once that register is free or being read.
// A stalled response holds the engine; the queue keeps taking requests until
// it is full, then req_bus.ready drops.
// Reset: the queue empties, no frame runs, the held read byte is 0 and
// half_period_ticks 1; the response register fields are not reset.
module spi_master_addr16_data8
   import spi_ma_pkg::*;
#(
   parameter int ADDRESS_BITS = 16,
   parameter int DATA_BITS    = 8
)
(
   input  logic                  clock,
   input  logic                  reset,
   spi_ma_req_if.sink            req_bus,
   spi_ma_rsp_if.source          rsp_bus,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   logic [7:0]       half_ff;
   logic             csr_wr;
   logic             pop;
   queue_status_type q_status;
   req_item_type     head;

   // configuration register
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff <= HALF_RESET;
      end else if (csr_wr && (csr_paddr[2] == CSR_IDX_HALF)) begin
         half_ff <= csr_pwdata[7:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == CSR_IDX_HALF) ? {24'd0, half_ff} : 32'd0;

   // request front and queue
   spi_ma_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .pop     (pop),
      .status  (q_status),
      .head    (head)
   );

   // frame engine
   spi_ma_engine #(
      .ADDRESS_BITS (ADDRESS_BITS),
      .DATA_BITS    (DATA_BITS)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .half_period (half_ff),
      .q_status    (q_status),
      .head        (head),
      .pop         (pop),
      .rsp_bus     (rsp_bus)
   );

   // checks
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.done_res |-> rsp_bus.chip_select_n && !rsp_bus.busy_res)
      else $error("done without frame end");

   a_busy_cs: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (rsp_bus.busy_res != rsp_bus.chip_select_n))
      else $error("chip select disagrees with busy");

   a_pop_rsp: assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_bus.valid)
      else $error("tick taken without response");

   a_queue_level: assert property (@(posedge clock) disable iff (reset)
      q_status.level <= QUEUE_CNT_W'(QUEUE_DEPTH))
      else $error("request queue overflow");

endmodule

// ===== hw/rtl/spi_ma_front.sv =====
module spi_ma_front
   import spi_ma_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   spi_ma_req_if.sink       req_bus,
   input  logic             pop,
   output queue_status_type status,
   output req_item_type     head
);

   req_item_type           mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   push;
   logic                   do_pop;
   req_item_type           item;

   // accept while there is room
   assign req_bus.ready = (count_ff < QUEUE_CNT_W'(QUEUE_DEPTH));
   assign push          = req_bus.valid && req_bus.ready;
   assign do_pop        = pop && (count_ff != '0);

   // pack the request
   always_comb begin
      item.start_req  = req_bus.start_req;
      item.command    = req_bus.command;
      item.address    = req_bus.address;
      item.write_data = req_bus.write_data;
      item.miso       = req_bus.miso;
   end

   // pointer and fill level update
   always_comb begin
      wr_ptr_in = push   ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= item;
      end
   end

   assign head         = mem_ff[rd_ptr_ff];
   assign status.valid = (count_ff != '0);
   assign status.level = count_ff;

endmodule

// ===== hw/rtl/spi_ma_engine.sv =====
module spi_ma_engine
   import spi_ma_pkg::*;
#(
   parameter int ADDRESS_BITS = 16,
   parameter int DATA_BITS    = 8
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic [7:0]       half_period,
   input  queue_status_type q_status,
   input  req_item_type     head,
   output logic             pop,
   spi_ma_rsp_if.source     rsp_bus
);

   localparam int TOTAL = ADDRESS_BITS + DATA_BITS;
   localparam int CNT_W = $clog2(TOTAL + 1);
   localparam logic [CNT_W-1:0] TOTAL_C = CNT_W'(TOTAL);
   localparam logic [CNT_W-1:0] ADDR_C  = CNT_W'(ADDRESS_BITS);

   logic [TOTAL-1:0]     shift_out_ff, shift_out_in;
   logic [DATA_BITS-1:0] shift_in_ff, shift_in_in;
   logic [CNT_W-1:0]     bit_count_ff, bit_count_in;
   logic [7:0]           tick_count_ff, tick_count_in;
   logic                 clock_level_ff, clock_level_in;
   logic                 active_ff, active_in;
   logic                 is_read_ff, is_read_in;
   logic [7:0]           read_hold_ff, read_hold_in;
   logic                 done;
   logic [7:0]           half_eff;
   logic [31:0]          addr_wide;
   logic [31:0]          data_wide;
   logic [ADDRESS_BITS-2:0] addr_bits;
   logic [DATA_BITS-1:0]    data_bits;

   logic       rsp_valid_ff;
   logic       cs_n_ff, sclk_ff, sout_ff, busy_ff, done_ff;
   logic [7:0] rdata_ff;

   // take the next tick when the result register frees up
   assign pop = q_status.valid && (!rsp_valid_ff || rsp_bus.ready);

   assign half_eff  = (half_period == 8'd0) ? 8'd1 : half_period;
   assign addr_wide = 32'(head.address);
   assign data_wide = 32'(head.write_data);
   assign addr_bits = addr_wide[ADDRESS_BITS-2:0];
   assign data_bits = data_wide[DATA_BITS-1:0];

   // one tick of frame timing
   always_comb begin
      shift_out_in   = shift_out_ff;
      shift_in_in    = shift_in_ff;
      bit_count_in   = bit_count_ff;
      tick_count_in  = tick_count_ff;
      clock_level_in = clock_level_ff;
      active_in      = active_ff;
      is_read_in     = is_read_ff;
      read_hold_in   = read_hold_ff;
      done           = 1'b0;
      if (!active_ff) begin
         if (head.start_req) begin
            is_read_in     = (head.command == CMD_READ);
            shift_out_in   = {is_read_in, addr_bits,
                              is_read_in ? {DATA_BITS{1'b0}} : data_bits};
            shift_in_in    = '0;
            bit_count_in   = '0;
            tick_count_in  = '0;
            clock_level_in = 1'b0;
            active_in      = 1'b1;
         end
      end else begin
         tick_count_in = tick_count_ff + 8'd1;
         if (tick_count_in >= half_eff) begin
            tick_count_in = '0;
            if (!clock_level_ff) begin
               // rising edge: sample miso in the data phase of a read
               clock_level_in = 1'b1;
               if (is_read_ff && (bit_count_ff >= ADDR_C)) begin
                  shift_in_in = {shift_in_ff[DATA_BITS-2:0], head.miso};
               end
            end else begin
               // falling edge: next bit out, end of frame after the last one
               clock_level_in = 1'b0;
               bit_count_in   = bit_count_ff + 1'b1;
               shift_out_in   = {shift_out_ff[TOTAL-2:0], 1'b0};
               if (bit_count_in >= TOTAL_C) begin
                  active_in    = 1'b0;
                  done         = 1'b1;
                  bit_count_in = '0;
                  if (is_read_ff) begin
                     read_hold_in = shift_in_ff[7:0];
                  end
               end
            end
         end
      end
   end

   // frame state
   always_ff @(posedge clock) begin
      if (reset) begin
         shift_out_ff   <= '0;
         shift_in_ff    <= '0;
         bit_count_ff   <= '0;
         tick_count_ff  <= '0;
         clock_level_ff <= 1'b0;
         active_ff      <= 1'b0;
         is_read_ff     <= 1'b0;
         read_hold_ff   <= '0;
      end else if (pop) begin
         shift_out_ff   <= shift_out_in;
         shift_in_ff    <= shift_in_in;
         bit_count_ff   <= bit_count_in;
         tick_count_ff  <= tick_count_in;
         clock_level_ff <= clock_level_in;
         active_ff      <= active_in;
         is_read_ff     <= is_read_in;
         read_hold_ff   <= read_hold_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pop) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cs_n_ff  <= !active_in;
         sclk_ff  <= active_in && clock_level_in;
         sout_ff  <= active_in && shift_out_in[TOTAL-1];
         busy_ff  <= active_in;
         done_ff  <= done;
         rdata_ff <= read_hold_in;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.chip_select_n = cs_n_ff;
   assign rsp_bus.serial_clock  = sclk_ff;
   assign rsp_bus.serial_out    = sout_ff;
   assign rsp_bus.busy_res      = busy_ff;
   assign rsp_bus.done_res      = done_ff;
   assign rsp_bus.read_data     = rdata_ff;

endmodule

// ===== tb/tb_spi_master_addr16_data8.sv =====
`timescale 1ns / 1ps

module tb_spi_master_addr16_data8;
   import spi_ma_pkg::*;

   localparam int FRAME_BITS     = 24;
   localparam int ADDR_BITS      = 16;
   localparam int STALL_PCT      = 12;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_TICKS   = 360;
   localparam logic [CSR_ADDR_W-1:0] HALF_ADDR = {CSR_IDX_HALF, 2'b00};

   // pin and status levels after one tick
   typedef struct packed {
      logic       chip_select_n;
      logic       serial_clock;
      logic       serial_out;
      logic       busy;
      logic       done;
      logic [7:0] read_data;
   } pin_state_type;

   // one line of the directed stimulus
   typedef struct {
      req_item_type  tick;
      int unsigned   reps;
      bit            fixed;
      pin_state_type pins;
   } tick_row_type;

   localparam pin_state_type NO_PINS = '0;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0]           csr_pwdata;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   spi_ma_req_if req_bus ();
   spi_ma_rsp_if rsp_bus ();

   // predictor state
   logic [23:0] tx_frame;
   logic [7:0]  rx_byte;
   logic [7:0]  last_read_byte;
   logic [7:0]  half_ticks;
   logic [7:0]  tick_idx;
   logic [4:0]  bit_idx;
   logic        sclk_level;
   logic        in_frame;
   logic        frame_is_read;

   pin_state_type pin_queue[$];
   int unsigned error_count  = 0;
   int unsigned ticks_sent   = 0;
   int unsigned frames_seen  = 0;
   int unsigned cycle_count  = 0;
   int unsigned quiet_cycles = 0;
   logic        calm;

   // stretches with no idling on either side
   assign calm = ((cycle_count % 1000) >= 400) && ((cycle_count % 1000) < 600);

   always #6 clock = ~clock;

   spi_master_addr16_data8 i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // predictor: advance the serial timing by one tick
   function automatic pin_state_type predict_pins(input req_item_type t);
      pin_state_type p;
      logic [7:0] half;
      half   = (half_ticks == 8'd0) ? 8'd1 : half_ticks;
      p.done = 1'b0;
      if (!in_frame) begin
         if (t.start_req) begin
            frame_is_read = (t.command == CMD_READ);
            tx_frame   = {frame_is_read, t.address, frame_is_read ? 8'h00 : t.write_data};
            rx_byte    = '0;
            bit_idx    = '0;
            tick_idx   = '0;
            sclk_level = 1'b0;
            in_frame   = 1'b1;
         end
      end else begin
         tick_idx = tick_idx + 8'd1;
         if (tick_idx >= half) begin
            tick_idx = '0;
            if (!sclk_level) begin
               // rising edge: take miso in the data phase of a read
               sclk_level = 1'b1;
               if (frame_is_read && bit_idx >= ADDR_BITS) begin
                  rx_byte = {rx_byte[6:0], t.miso};
               end
            end else begin
               // falling edge: next bit, frame ends after the last one
               sclk_level = 1'b0;
               bit_idx    = bit_idx + 5'd1;
               tx_frame   = tx_frame << 1;
               if (bit_idx >= FRAME_BITS) begin
                  in_frame = 1'b0;
                  p.done   = 1'b1;
                  bit_idx  = '0;
                  if (frame_is_read) begin
                     last_read_byte = rx_byte;
                  end
               end
            end
         end
      end
      p.chip_select_n = !in_frame;
      p.serial_clock  = in_frame & sclk_level;
      p.serial_out    = in_frame & tx_frame[FRAME_BITS-1];
      p.busy          = in_frame;
      p.read_data     = last_read_byte;
      return p;
   endfunction

   task automatic predictor_reset();
      tx_frame       = '0;
      rx_byte        = '0;
      last_read_byte = '0;
      half_ticks     = HALF_RESET;
      tick_idx       = '0;
      bit_idx        = '0;
      sclk_level     = 1'b0;
      in_frame       = 1'b0;
      frame_is_read  = 1'b0;
   endtask

   function automatic pin_state_type pins(input logic cs_n, input logic sclk, input logic sout,
                                          input logic busy, input logic done,
                                          input logic [7:0] rd);
      pin_state_type p;
      p = {cs_n, sclk, sout, busy, done, rd};
      return p;
   endfunction

   function automatic tick_row_type tick_row(input logic start, input logic cmd,
                                             input logic [14:0] addr, input logic [7:0] wdata,
                                             input logic miso, input int unsigned reps,
                                             input bit fixed, input pin_state_type p);
      tick_row_type r;
      r.tick  = {start, cmd, addr, wdata, miso};
      r.reps  = reps;
      r.fixed = fixed;
      r.pins  = p;
      return r;
   endfunction

   function automatic req_item_type random_tick();
      req_item_type t;
      t.start_req = ($urandom_range(3) == 0);
      t.command   = ($urandom_range(1) == 1) ? CMD_READ : CMD_WRITE;
      case ($urandom_range(7))
         0: t.address = '0;
         1: t.address = '1;
         default: t.address = 15'($urandom_range(32767));
      endcase
      case ($urandom_range(7))
         0: t.write_data = '0;
         1: t.write_data = '1;
         default: t.write_data = 8'($urandom_range(255));
      endcase
      t.miso = 1'($urandom_range(1));
      return t;
   endfunction

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s expected %0h got %0h", name, want, got);
         error_count++;
      end
   endtask

   // one request, with random idle cycles ahead of it
   task automatic send_tick(input req_item_type t, input bit fixed, input pin_state_type want);
      pin_state_type p;
      while (!calm && $urandom_range(99) < STALL_PCT) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.start_req  <= t.start_req;
      req_bus.command    <= t.command;
      req_bus.address    <= t.address;
      req_bus.write_data <= t.write_data;
      req_bus.miso       <= t.miso;
      do @(posedge clock); while (!req_bus.ready);
      p = predict_pins(t);
      if (p.done) begin
         frames_seen++;
      end
      ticks_sent++;
      pin_queue.push_back(fixed ? want : p);
   endtask

   // apb transfer: setup, then access until pready, then idle
   task automatic csr_access(input logic wr, input logic [7:0] value,
                             output logic [31:0] rd);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= HALF_ADDR;
      csr_pwdata  <= {24'h0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rd = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // change the half period once every response is back, then read it back
   task automatic set_half(input logic [7:0] half);
      logic [31:0] rd;
      while (pin_queue.size() != 0) @(posedge clock);
      csr_access(1'b1, half, rd);
      half_ticks = half;
      csr_access(1'b0, 8'h00, rd);
      check_field("half_period_ticks", half, rd[7:0]);
   endtask

   // random ticks until the given number of frames have finished
   task automatic run_phase(input logic [7:0] half, input int unsigned frames);
      int unsigned goal;
      set_half(half);
      goal = frames_seen + frames;
      while (frames_seen < goal || in_frame) begin
         send_tick(random_tick(), 1'b0, NO_PINS);
      end
      req_bus.valid <= 1'b0;
   endtask

   // response side: random stalls and field checks
   always @(posedge clock) begin : rsp_check
      pin_state_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= calm || ($urandom_range(99) >= STALL_PCT);
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pin_queue.size() == 0) begin
               $error("response with no request outstanding");
               error_count++;
            end else begin
               want = pin_queue.pop_front();
               check_field("chip_select_n", want.chip_select_n, rsp_bus.chip_select_n);
               check_field("serial_clock", want.serial_clock, rsp_bus.serial_clock);
               check_field("serial_out", want.serial_out, rsp_bus.serial_out);
               check_field("busy_res", want.busy, rsp_bus.busy_res);
               check_field("done_res", want.done, rsp_bus.done_res);
               check_field("read_data", want.read_data, rsp_bus.read_data);
            end
         end
      end
   end

   // watchdog on cycles with no transfer anywhere
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset || csr_psel || (req_bus.valid && req_bus.ready) ||
          (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_spi_master_addr16_data8 failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : main
      tick_row_type dir_table[12];
      logic [31:0]  rd;
      logic [7:0]   small_halves[4];
      int unsigned  phase_no;
      int unsigned  dir_ticks;

      reset              <= 1'b1;
      csr_psel           <= 1'b0;
      csr_penable        <= 1'b0;
      csr_pwrite         <= 1'b0;
      csr_paddr          <= '0;
      csr_pwdata         <= '0;
      req_bus.valid      <= 1'b0;
      req_bus.start_req  <= 1'b0;
      req_bus.command    <= CMD_WRITE;
      req_bus.address    <= '0;
      req_bus.write_data <= '0;
      req_bus.miso       <= 1'b0;
      predictor_reset();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset value of the half period, then an explicit write of it
      csr_access(1'b0, 8'h00, rd);
      check_field("half_period_ticks", HALF_RESET, rd[7:0]);
      set_half(HALF_RESET);

      // directed frames at one tick per half period: 48 ticks after the start
      dir_table[0]  = tick_row(1'b0, CMD_WRITE, 15'h0000, 8'h00, 1'b0, 2, 1'b1,
                               pins(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00));
      // write, all-ones address and data, flag bit goes out low
      dir_table[1]  = tick_row(1'b1, CMD_WRITE, 15'h7fff, 8'hff, 1'b0, 1, 1'b1,
                               pins(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00));
      // starts while busy are ignored
      dir_table[2]  = tick_row(1'b1, CMD_READ, 15'h0000, 8'h00, 1'b1, 47, 1'b0, NO_PINS);
      // start on the done tick is ignored too
      dir_table[3]  = tick_row(1'b1, CMD_READ, 15'h0000, 8'h00, 1'b1, 1, 1'b1,
                               pins(1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 8'h00));
      // read of the top address with miso high, write data unused
      dir_table[4]  = tick_row(1'b1, CMD_READ, 15'h7fff, 8'hff, 1'b1, 1, 1'b1,
                               pins(1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 8'h00));
      dir_table[5]  = tick_row(1'b0, CMD_WRITE, 15'h0000, 8'h00, 1'b1, 47, 1'b0, NO_PINS);
      dir_table[6]  = tick_row(1'b0, CMD_WRITE, 15'h0000, 8'h00, 1'b1, 1, 1'b1,
                               pins(1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 8'hff));
      // write to address zero keeps the last read byte
      dir_table[7]  = tick_row(1'b1, CMD_WRITE, 15'h0000, 8'h00, 1'b0, 1, 1'b1,
                               pins(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 8'hff));
      dir_table[8]  = tick_row(1'b0, CMD_WRITE, 15'h0000, 8'h00, 1'b0, 48, 1'b0, NO_PINS);
      // read of address zero with miso low
      dir_table[9]  = tick_row(1'b1, CMD_READ, 15'h0000, 8'hff, 1'b0, 1, 1'b1,
                               pins(1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 8'hff));
      dir_table[10] = tick_row(1'b0, CMD_WRITE, 15'h0000, 8'h00, 1'b0, 48, 1'b0, NO_PINS);
      dir_table[11] = tick_row(1'b0, CMD_WRITE, 15'h0000, 8'h00, 1'b0, 1, 1'b1,
                               pins(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00));

      foreach (dir_table[i]) begin
         repeat (dir_table[i].reps) begin
            send_tick(dir_table[i].tick, dir_table[i].fixed, dir_table[i].pins);
         end
      end
      req_bus.valid <= 1'b0;
      dir_ticks = ticks_sent;

      // random frames at short half periods, zero among them
      small_halves = '{8'd0, 8'd2, 8'd1, 8'd3};
      phase_no = 0;
      while (ticks_sent < dir_ticks + RANDOM_TICKS) begin
         if (phase_no < 4) begin
            run_phase(small_halves[phase_no], 1);
         end else begin
            run_phase(8'($urandom_range(1, 3)), 1);
         end
         phase_no++;
      end

      // longest half period for a stretch, then a change to one with the frame running
      set_half(8'd255);
      repeat (40) begin
         send_tick(random_tick(), 1'b0, NO_PINS);
      end
      req_bus.valid <= 1'b0;
      run_phase(8'd1, 0);

      while (pin_queue.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_spi_master_addr16_data8 passed");
      end else begin
         $display("tb_spi_master_addr16_data8 failed");
      end
      $finish;
   end

endmodule

// ===== spi_master_addr16_data8.f =====
hw/rtl/spi_ma_pkg.sv
hw/rtl/spi_ma_req_if.sv
hw/rtl/spi_ma_rsp_if.sv
hw/rtl/spi_ma_front.sv
hw/rtl/spi_ma_engine.sv
hw/rtl/spi_master_addr16_data8.sv
tb/tb_spi_master_addr16_data8.sv
